// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: invariant");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/cbms_pkg.sv
// ----------------------------------------------------------------------------
// cbms_pkg
// Widths, constants and the CRC-8 check function of the block maximum selector.
// ----------------------------------------------------------------------------
package cbms_pkg;

	localparam int WORD_W  = 32;
	localparam int VALUE_W = 24;
	localparam int CRC_W   = 8;
	localparam int INDEX_W = 8;

	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

	// The CRC starts at zero and is linear, so each value bit adds a fixed
	// column to the result. The columns follow from the 0x1D right-shift step.
	localparam logic [CRC_W-1:0] CRC_COL [VALUE_W] = '{
		8'h0D, 8'h07, 8'h0E, 8'h01, 8'h02, 8'h04, 8'h08, 8'h0D,
		8'h07, 8'h0E, 8'h01, 8'h02, 8'h04, 8'h08, 8'h0D, 8'h07,
		8'h0E, 8'h01, 8'h02, 8'h04, 8'h08, 8'h0D, 8'h07, 8'h0E
	};

	function automatic logic [CRC_W-1:0] crc8_of(input logic [VALUE_W-1:0] value);
		logic [CRC_W-1:0] crc;
		crc = '0;
		for (int i = 0; i < VALUE_W; i++) begin
			if (value[i]) begin
				crc = crc ^ CRC_COL[i];
			end
		end
		return crc;
	endfunction

endpackage

// File: sv/crc_checked_block_max_select.sv
// Pipeline: an input register, then a result register, from input transaction to result.
// Throughput: one block word per cycle unless the output stalls; the CRC is a flat XOR
// network, the running maximum a single 24-bit compare, both between the two registers.
// Reset: arst_n clears the pipeline valids, the kept maximum and the run position.
// The run state also clears itself after the block marked last.
// ----------------------------------------------------------------------------
// crc_checked_block_max_select
// Checks each stored block word against its CRC-8 and tracks the largest valid value.
// ----------------------------------------------------------------------------
module crc_checked_block_max_select
	import cbms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WORD_W-1:0]   block_word,
	input  logic                last_block,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  max_value,
	output logic [INDEX_W-1:0]  max_index,
	output logic                block_valid,
	output logic                run_done
);

	logic                valid_s1;
	logic [WORD_W-1:0]   word_s1;
	logic                last_s1;

	logic                valid_s2;
	logic [VALUE_W-1:0]  max_value_s2;
	logic [INDEX_W-1:0]  max_index_s2;
	logic                block_valid_s2;
	logic                run_done_s2;

	logic [VALUE_W-1:0]  best_value_q;
	logic [INDEX_W-1:0]  best_pos_q;
	logic [INDEX_W-1:0]  block_pos_q;

	logic                adv_s2;
	logic                adv_s1;
	logic [VALUE_W-1:0]  value;
	logic                crc_ok;
	logic                take;
	logic [VALUE_W-1:0]  next_value;
	logic [INDEX_W-1:0]  next_pos;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign adv_s1   = valid_s1 && adv_s2;

	assign value      = word_s1[WORD_W-1 -: VALUE_W];
	assign crc_ok     = (crc8_of(value) == word_s1[CRC_W-1:0]);
	assign take       = crc_ok && (value > best_value_q);
	assign next_value = take ? value : best_value_q;
	assign next_pos   = take ? block_pos_q : best_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= block_word;
			last_s1 <= last_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			best_value_q <= '0;
			best_pos_q   <= '0;
			block_pos_q  <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				if (last_s1) begin
					best_value_q <= '0;
					best_pos_q   <= '0;
					block_pos_q  <= '0;
				end else begin
					best_value_q <= next_value;
					best_pos_q   <= next_pos;
					// The position sticks at its top value on long runs.
					if (block_pos_q != INDEX_MAX) begin
						block_pos_q <= block_pos_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			max_value_s2   <= next_value;
			max_index_s2   <= next_pos;
			block_valid_s2 <= crc_ok;
			run_done_s2    <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign max_value   = max_value_s2;
	assign max_index   = max_index_s2;
	assign block_valid = block_valid_s2;
	assign run_done    = run_done_s2;

endmodule

// File: sv/cbms_checker.sv
// ----------------------------------------------------------------------------
// cbms_checker
// Port-level assertions for the block maximum selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbms_checker
	import cbms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [WORD_W-1:0]   block_word,
	input  logic                last_block,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [VALUE_W-1:0]  max_value,
	input  logic [INDEX_W-1:0]  max_index,
	input  logic                block_valid,
	input  logic                run_done
);

	// A stalled result transaction keeps its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(max_value) && $stable(max_index) && $stable(block_valid) && $stable(run_done))

	// With an empty output stage the input side never stalls.
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, out_valid || in_ready)

	// A zero maximum can only come from the empty default, never from a kept block.
	`ASSERT_ALWAYS(a_zero_max_index, clk, arst_n, !out_valid || (max_value != '0) || (max_index == '0))

	// An input accepted with out_ready high always leads to out_valid, through the input and result registers.
	`ASSERT_NEXT(a_result_follows, clk, arst_n, in_valid && in_ready && out_ready, ##1 out_valid)

endmodule

bind crc_checked_block_max_select cbms_checker u_cbms_checker (.*);

// File: dv/tb_crc_checked_block_max_select.sv
// ----------------------------------------------------------------------------
// tb_crc_checked_block_max_select
// Drives runs of stored block words through the CRC-checked maximum selector.
// A bitwise CRC-8 and a running-maximum tracker predict every result, and a
// monitor checks each output transaction field by field against the oldest
// prediction. Phases vary sender idling and receiver stalls, and one phase
// holds the receiver off for a long stretch so the block fills up.
// ----------------------------------------------------------------------------
module tb_crc_checked_block_max_select;
	import cbms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CRC_W-1:0] CRC_POLY = 8'h1D;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} block_item_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
		logic               valid;
		logic               done;
	} max_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [WORD_W-1:0]  block_word = '0;
	logic               last_block = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] max_value;
	logic [INDEX_W-1:0] max_index;
	logic               block_valid;
	logic               run_done;

	block_item_t block_queue[$];
	max_result_t expected_results[$];

	// Running state of the predicted maximum tracker.
	logic [VALUE_W-1:0] run_best_value = '0;
	logic [INDEX_W-1:0] run_best_index = '0;
	logic [INDEX_W-1:0] run_position = '0;

	int  sender_idle_pct = 0;
	int  receiver_stall_pct = 0;
	bit  hold_off = 1'b0;
	bit  in_took = 1'b0;
	int  issued_count = 0;
	int  accepted_count = 0;
	int  fail_count = 0;

	crc_checked_block_max_select dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.block_word  (block_word),
		.last_block  (last_block),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_value   (max_value),
		.max_index   (max_index),
		.block_valid (block_valid),
		.run_done    (run_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Right-shifting CRC-8, value bytes taken low byte first, one bit per step.
	function automatic logic [CRC_W-1:0] crc8_lsb_first(input logic [VALUE_W-1:0] v);
		logic [CRC_W-1:0] crc;
		crc = '0;
		for (int b = 0; b < VALUE_W / 8; b++) begin
			crc = crc ^ v[8*b +: 8];
			for (int k = 0; k < 8; k++) begin
				if (crc[0]) begin
					crc = crc ^ CRC_POLY;
				end
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

	function automatic logic [WORD_W-1:0] sealed_word(input logic [VALUE_W-1:0] v);
		return {v, crc8_lsb_first(v)};
	endfunction

	task automatic predict_block_max(input logic [WORD_W-1:0] w, input logic last);
		logic [VALUE_W-1:0] v;
		logic               ok;
		max_result_t        r;
		v = w[WORD_W-1:CRC_W];
		ok = (crc8_lsb_first(v) == w[CRC_W-1:0]);
		if (ok && v > run_best_value) begin
			run_best_value = v;
			run_best_index = run_position;
		end
		r.value = run_best_value;
		r.index = run_best_index;
		r.valid = ok;
		r.done = last;
		expected_results.push_back(r);
		if (run_position != INDEX_MAX) begin
			run_position++;
		end
		if (last) begin
			run_best_value = '0;
			run_best_index = '0;
			run_position = '0;
		end
	endtask

	task automatic push_block(input logic [WORD_W-1:0] w, input logic last);
		block_item_t item;
		item.word = w;
		item.last = last;
		block_queue.push_back(item);
		issued_count++;
	endtask

	// One run of blocks: mostly sealed words, with ties, climbing values,
	// corrupted checks and raw noise mixed in.
	task automatic queue_run(input int len);
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] seen;
		logic [CRC_W-1:0]   flip;
		int                 pick;
		seen = '0;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: v = 24'($urandom);
				1: v = 24'($urandom_range(0, 255));
				2: v = (seen > 24'hFFFC00) ? seen : seen + 24'($urandom_range(1, 1000));
				default: v = {8'hFF, 16'($urandom)};
			endcase
			pick = $urandom_range(99);
			if (pick < 58) begin
				push_block(sealed_word(v), i == len - 1);
				seen = v;
			end else if (pick < 72) begin
				push_block(sealed_word(seen), i == len - 1);
			end else if (pick < 88) begin
				flip = 8'($urandom_range(1, 255));
				push_block(sealed_word(v) ^ {24'h0, flip}, i == len - 1);
			end else begin
				push_block($urandom, i == len - 1);
			end
		end
	endtask

	task automatic queue_random_runs(input int n_items);
		int left;
		int len;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			if (len > left) begin
				len = left;
			end
			queue_run(len);
			left -= len;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_count != issued_count || expected_results.size() != 0);
	endtask

	task automatic set_idling(input int s_idle, input int r_stall);
		wait_drained();
		@(posedge clk);
		sender_idle_pct = s_idle;
		receiver_stall_pct = r_stall;
	endtask

	// Sender and receiver: both change their pins at the falling edge.
	always @(negedge clk) begin
		block_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_took) begin
				if (block_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item = block_queue.pop_front();
					in_valid <= 1'b1;
					block_word <= item.word;
					last_block <= item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		max_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no prediction waiting");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (max_value !== want.value) begin
					$error("max_value: expected %0h, actual %0h", want.value, max_value);
					fail_count++;
				end
				if (max_index !== want.index) begin
					$error("max_index: expected %0d, actual %0d", want.index, max_index);
					fail_count++;
				end
				if (block_valid !== want.valid) begin
					$error("block_valid: expected %0b, actual %0b", want.valid, block_valid);
					fail_count++;
				end
				if (run_done !== want.done) begin
					$error("run_done: expected %0b, actual %0b", want.done, run_done);
					fail_count++;
				end
			end
		end
		in_took = arst_n && in_valid && in_ready;
		if (in_took) begin
			predict_block_max(block_word, last_block);
			accepted_count++;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero values, full-scale values, ties, bad checks and run ends.
		push_block(sealed_word(24'h000000), 1'b0);
		push_block(sealed_word(24'h000001), 1'b0);
		push_block(sealed_word(24'hFFFFFF) ^ 32'h0000_0001, 1'b0);
		push_block(sealed_word(24'hFFFFFF), 1'b0);
		push_block(sealed_word(24'hFFFFFF), 1'b0);
		push_block(sealed_word(24'h000000), 1'b0);
		push_block(sealed_word(24'h7FFFFF), 1'b1);
		push_block(32'hFFFF_FFFF, 1'b1);
		push_block(32'h0000_00FF, 1'b0);
		push_block(sealed_word(24'h800000), 1'b0);
		push_block(sealed_word(24'h800001) ^ 32'h0000_0080, 1'b0);
		push_block(sealed_word(24'h555555), 1'b0);
		push_block(sealed_word(24'hAAAAAA), 1'b1);
		push_block(sealed_word(24'h000000), 1'b1);
		push_block(sealed_word(24'h123456), 1'b0);
		push_block(32'h0000_0000, 1'b1);
		queue_random_runs(80);

		set_idling(52, 0);
		queue_random_runs(100);
		set_idling(0, 52);
		queue_random_runs(100);
		set_idling(24, 24);
		queue_random_runs(100);

		// The receiver holds off while a long run streams in, so the block
		// backs up; the run is long enough for the position to saturate.
		set_idling(0, 0);
		hold_off = 1'b1;
		queue_run(270);
		repeat (300) @(posedge clk);
		hold_off = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
